// ===== rtl/core/tvd_pkg.sv =====
// Shared constants and types for the tolerant vertex dedup block.
`default_nettype none
package tvd_pkg;
	localparam int TABLE_DEPTH = 1024;
	localparam int COORD_W     = 24;
	localparam int NUM_COMP    = 8;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int COUNT_W     = ADDR_W + 1;
	localparam int TOL_W       = COORD_W - 1;
	localparam int IDX_W       = 10;
	localparam int PADDR_W     = 2;
	localparam int PDATA_W     = 32;

	localparam logic [TOL_W-1:0]   TOL_RESET = TOL_W'(41);
	localparam logic [PADDR_W-1:0] REG_TOL   = PADDR_W'(0);

	typedef logic [NUM_COMP-1:0][COORD_W-1:0] vtx_t;

	typedef struct packed {
		logic               valid;
		logic               hit;
		logic [COUNT_W-1:0] idx;
	} match_t;
endpackage
`default_nettype wire

// ===== rtl/core/tvd_store.sv =====
// Unique-vertex table memory: one write port, one registered read port.
`default_nettype none
module tvd_store (
	input  wire logic                      clk,
	input  wire logic                      wr_en,
	input  wire logic [tvd_pkg::ADDR_W-1:0] wr_addr,
	input  wire tvd_pkg::vtx_t             wr_data,
	input  wire logic                      rd_en,
	input  wire logic [tvd_pkg::ADDR_W-1:0] rd_addr,
	output tvd_pkg::vtx_t                  rd_data_s1
);
	tvd_pkg::vtx_t mem [tvd_pkg::TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/tvd_match.sv =====
// Shared compare unit: checks all components of one stored entry per cycle.
`default_nettype none
module tvd_match (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       flush,
	input  wire logic                       rd_valid_s1,
	input  wire logic [tvd_pkg::COUNT_W-1:0] rd_idx_s1,
	input  wire tvd_pkg::vtx_t              rd_data_s1,
	input  wire tvd_pkg::vtx_t              vtx,
	input  wire logic [tvd_pkg::TOL_W-1:0]  tol,
	output tvd_pkg::match_t                 res_s2
);
	localparam int DW = tvd_pkg::COORD_W + 1;

	logic [tvd_pkg::NUM_COMP-1:0] near;
	logic [DW-1:0]                tol_ext;

	assign tol_ext = DW'(tol);

	always_comb begin
		logic signed [DW-1:0] d;
		logic [DW-1:0]        mag;
		for (int c = 0; c < tvd_pkg::NUM_COMP; c++) begin
			d = signed'({vtx[c][tvd_pkg::COORD_W-1], vtx[c]})
			    - signed'({rd_data_s1[c][tvd_pkg::COORD_W-1], rd_data_s1[c]});
			mag = d[DW-1] ? DW'(-d) : DW'(d);
			near[c] = (mag < tol_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else begin
			res_s2.valid <= rd_valid_s1 && !flush;
			res_s2.hit   <= &near;
			res_s2.idx   <= rd_idx_s1;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/tolerant_vertex_dedup.sv =====
// Tolerant vertex dedup: builds an index buffer from a stream of vertices.
//
// Vertex channel (vtx_valid / vtx_stall): one vertex per item, eight signed
// Q12.12 components plus clear_table, which empties the table first.
// Result channel (res_valid / res_stall): vertex_index, is_new, table_full.
// One result per vertex, in order.
// The table is scanned from entry 0 upward, one entry per cycle through a
// single registered memory read port and one shared compare unit. A hit
// stops the scan at the lowest matching entry; a miss scans every stored
// entry, then appends the vertex if the table has room. The memory read
// is registered, then the compare result and the pending result; FINISH
// loads the output register. vtx_stall is high from acceptance until the
// result is loaded; a new vertex may be taken while the previous result waits.
// A stalled result holds; the finished search waits for the output register.
// Reset empties the table and sets match_tolerance to 41 (0.01 in Q12.12).
// match_tolerance sits at APB byte address 0; strict less-than per component.
`default_nettype none
module tolerant_vertex_dedup (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [tvd_pkg::PADDR_W-1:0]       paddr,
	input  wire logic [tvd_pkg::PDATA_W-1:0]       pwdata,
	output logic      [tvd_pkg::PDATA_W-1:0]       prdata,
	output logic                                   pready,
	input  wire logic                              vtx_valid,
	output logic                                   vtx_stall,
	input  wire logic                              clear_table,
	input  wire logic signed [tvd_pkg::COORD_W-1:0] pos_x,
	input  wire logic signed [tvd_pkg::COORD_W-1:0] pos_y,
	input  wire logic signed [tvd_pkg::COORD_W-1:0] pos_z,
	input  wire logic signed [tvd_pkg::COORD_W-1:0] tex_u,
	input  wire logic signed [tvd_pkg::COORD_W-1:0] tex_v,
	input  wire logic signed [tvd_pkg::COORD_W-1:0] norm_x,
	input  wire logic signed [tvd_pkg::COORD_W-1:0] norm_y,
	input  wire logic signed [tvd_pkg::COORD_W-1:0] norm_z,
	output logic                                   res_valid,
	input  wire logic                              res_stall,
	output logic [tvd_pkg::IDX_W-1:0]              vertex_index,
	output logic                                   is_new,
	output logic                                   table_full
);
	localparam int CW = tvd_pkg::COUNT_W;
	localparam int AW = tvd_pkg::ADDR_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t               state_q;
	logic [tvd_pkg::TOL_W-1:0] tol_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        issue_q;
	tvd_pkg::vtx_t        vtx_q;
	logic                 rd_valid_s1;
	logic [CW-1:0]        rd_idx_s1;
	tvd_pkg::vtx_t        rd_data_s1;
	tvd_pkg::match_t      match_s2;
	logic [CW-1:0]        pend_idx_q;
	logic                 pend_new_q;
	logic                 pend_full_q;
	logic                 res_valid_q;
	logic [CW-1:0]        res_idx_q;
	logic                 res_new_q;
	logic                 res_full_q;

	tvd_pkg::vtx_t        in_vtx;
	logic                 vtx_accept;
	logic                 cfg_write;
	logic                 issuing;
	logic                 found;
	logic                 drained;
	logic                 scan_end;
	logic                 room;
	logic                 wr_en;
	logic                 out_free;

	assign in_vtx = {norm_z, norm_y, norm_x, tex_v, tex_u, pos_z, pos_y, pos_x};

	assign pready     = 1'b1;
	assign cfg_write  = psel && penable && pwrite && pready && (paddr == tvd_pkg::REG_TOL);
	assign prdata     = (paddr == tvd_pkg::REG_TOL) ? tvd_pkg::PDATA_W'(tol_q) : '0;

	assign vtx_stall  = (state_q != ST_IDLE);
	assign vtx_accept = vtx_valid && !vtx_stall;

	assign issuing  = (state_q == ST_SCAN) && (issue_q < count_q);
	assign found    = (state_q == ST_SCAN) && match_s2.valid && match_s2.hit;
	assign drained  = (state_q == ST_SCAN) && !issuing && !rd_valid_s1 && !match_s2.valid;
	assign scan_end = found || drained;
	assign room     = (count_q < CW'(tvd_pkg::TABLE_DEPTH));
	// append on a miss with a free entry
	assign wr_en    = drained && !found && room;
	assign out_free = !res_valid_q || !res_stall;

	tvd_store u_store (
		.clk        (clk),
		.wr_en      (wr_en),
		.wr_addr    (count_q[AW-1:0]),
		.wr_data    (vtx_q),
		.rd_en      (issuing),
		.rd_addr    (issue_q[AW-1:0]),
		.rd_data_s1 (rd_data_s1)
	);

	tvd_match u_match (
		.clk         (clk),
		.arst_n      (arst_n),
		.flush       (scan_end),
		.rd_valid_s1 (rd_valid_s1),
		.rd_idx_s1   (rd_idx_s1),
		.rd_data_s1  (rd_data_s1),
		.vtx         (vtx_q),
		.tol         (tol_q),
		.res_s2      (match_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= tvd_pkg::TOL_RESET;
		end else if (cfg_write) begin
			tol_q <= pwdata[tvd_pkg::TOL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			issue_q     <= '0;
			rd_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall && state_q != ST_FINISH) begin
				res_valid_q <= 1'b0;
			end
			rd_valid_s1 <= issuing && !scan_end;
			case (state_q)
				ST_IDLE: begin
					if (vtx_accept) begin
						issue_q <= '0;
						if (clear_table) begin
							count_q <= '0;
						end
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issuing) begin
						issue_q <= issue_q + CW'(1);
					end
					if (scan_end) begin
						if (wr_en) begin
							count_q <= count_q + CW'(1);
						end
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// hold the result until the output register frees up
					if (out_free) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (vtx_accept) begin
			vtx_q <= in_vtx;
		end
		rd_idx_s1 <= issue_q;
		if (found) begin
			pend_idx_q  <= match_s2.idx;
			pend_new_q  <= 1'b0;
			pend_full_q <= 1'b0;
		end else if (drained) begin
			pend_idx_q  <= room ? count_q : '0;
			pend_new_q  <= room;
			pend_full_q <= !room;
		end
		if (state_q == ST_FINISH && out_free) begin
			res_idx_q  <= pend_idx_q;
			res_new_q  <= pend_new_q;
			res_full_q <= pend_full_q;
		end
	end

	assign res_valid    = res_valid_q;
	assign vertex_index = res_idx_q[tvd_pkg::IDX_W-1:0];
	assign is_new       = res_new_q;
	assign table_full   = res_full_q;
endmodule
`default_nettype wire

// ===== rtl/core/tvd_checker.sv =====
// Port-level checks for the tolerant vertex dedup block, bound to the top level.
`default_nettype none
module tvd_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      vtx_valid,
	input wire logic                      vtx_stall,
	input wire logic                      res_valid,
	input wire logic                      res_stall,
	input wire logic [tvd_pkg::IDX_W-1:0] vertex_index,
	input wire logic                      is_new,
	input wire logic                      table_full
);
	// a stalled result stays up
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(is_new && table_full))
		else $error("is_new and table_full both set");

	a_full_idx: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && table_full |-> vertex_index == '0)
		else $error("full table result carries a nonzero index");

	// an accepted vertex raises vtx_stall while its search is in work
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid && !vtx_stall |=> vtx_stall)
		else $error("vertex taken while the previous one is in work");
endmodule

bind tolerant_vertex_dedup tvd_checker u_tvd_checker (.*);
`default_nettype wire

// ===== verif/tolerant_vertex_dedup_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for tolerant_vertex_dedup: directed, table-fill and random mesh items.
module tolerant_vertex_dedup_test;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 600;
	localparam int MESH_ITEMS     = 580;
	localparam int ROUNDS         = 6;
	localparam int CRD_W          = tvd_pkg::COORD_W;
	localparam int NCOMP          = tvd_pkg::NUM_COMP;

	localparam logic [CRD_W-1:0]          COORD_MAX = {1'b0, {(CRD_W-1){1'b1}}};
	localparam logic [CRD_W-1:0]          COORD_MIN = {1'b1, {(CRD_W-1){1'b0}}};
	localparam logic [tvd_pkg::TOL_W-1:0] TOL_MAX   = '1;

	// comp[0] is pos_x, comp[NCOMP-1] is norm_z
	typedef struct packed {
		logic          clear;
		tvd_pkg::vtx_t comp;
	} vertex_t;

	typedef struct packed {
		logic [tvd_pkg::IDX_W-1:0] idx;
		logic                      fresh;
		logic                      full;
	} lookup_t;

	logic                              clk;
	logic                              arst_n      = 1'b0;
	logic                              psel        = 1'b0;
	logic                              penable     = 1'b0;
	logic                              pwrite      = 1'b0;
	logic [tvd_pkg::PADDR_W-1:0]       paddr       = '0;
	logic [tvd_pkg::PDATA_W-1:0]       pwdata      = '0;
	logic [tvd_pkg::PDATA_W-1:0]       prdata;
	logic                              pready;
	logic                              vtx_valid   = 1'b0;
	logic                              vtx_stall;
	logic                              clear_table = 1'b0;
	logic signed [CRD_W-1:0]           pos_x       = '0;
	logic signed [CRD_W-1:0]           pos_y       = '0;
	logic signed [CRD_W-1:0]           pos_z       = '0;
	logic signed [CRD_W-1:0]           tex_u       = '0;
	logic signed [CRD_W-1:0]           tex_v       = '0;
	logic signed [CRD_W-1:0]           norm_x      = '0;
	logic signed [CRD_W-1:0]           norm_y      = '0;
	logic signed [CRD_W-1:0]           norm_z      = '0;
	logic                              res_valid;
	logic                              res_stall   = 1'b0;
	logic [tvd_pkg::IDX_W-1:0]         vertex_index;
	logic                              is_new;
	logic                              table_full;

	// Predictor state: tolerance and the unique-vertex table as the block should hold them
	int            tol_model  = int'(tvd_pkg::TOL_RESET);
	int            mesh_count = 0;
	tvd_pkg::vtx_t mesh_store [tvd_pkg::TABLE_DEPTH];

	vertex_t vertices_to_send [$];
	lookup_t indices_due [$];
	vertex_t next_item;
	lookup_t next_due;
	int      vertices_queued = 0;
	int      results_seen    = 0;
	int      fault_count     = 0;
	int      send_idle_pct   = 18;
	int      recv_idle_pct   = 18;
	int      hold_asks       = 0;
	int      hold_served     = 0;
	int      hold_left       = 0;
	int      quiet_cycles    = 0;

	tolerant_vertex_dedup u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic lookup_t lookup_vertex(input vertex_t v);
		lookup_t r;
		int      d;
		bit      near;
		r = '0;
		if (v.clear)
			mesh_count = 0;
		// first entry within tolerance on all components wins
		for (int e = 0; e < mesh_count; e++) begin
			near = 1'b1;
			for (int c = 0; c < NCOMP; c++) begin
				d = $signed(v.comp[c]) - $signed(mesh_store[e][c]);
				if (d < 0)
					d = -d;
				if (d >= tol_model)
					near = 1'b0;
			end
			if (near) begin
				r.idx = tvd_pkg::IDX_W'(e);
				return r;
			end
		end
		if (mesh_count >= tvd_pkg::TABLE_DEPTH) begin
			r.full = 1'b1;
			return r;
		end
		mesh_store[mesh_count] = v.comp;
		r.idx   = tvd_pkg::IDX_W'(mesh_count);
		r.fresh = 1'b1;
		mesh_count++;
		return r;
	endfunction

	function automatic vertex_t flat_vertex(input logic clear, input logic [CRD_W-1:0] value);
		vertex_t v;
		v.clear = clear;
		for (int c = 0; c < NCOMP; c++)
			v.comp[c] = value;
		return v;
	endfunction

	function automatic vertex_t random_vertex(input logic clear);
		vertex_t v;
		v.clear = clear;
		for (int c = 0; c < NCOMP; c++)
			v.comp[c] = CRD_W'($urandom);
		return v;
	endfunction

	// Perturb each component, either anywhere near the tolerance or right at its edge
	function automatic vertex_t jitter(input vertex_t base, input int span);
		vertex_t v;
		int      off;
		v = base;
		for (int c = 0; c < NCOMP; c++) begin
			if ($urandom_range(0, 1) == 1) begin
				off = $urandom_range(0, 2 * span) - span;
			end else begin
				off = tol_model - $urandom_range(0, 1);
				if ($urandom_range(0, 1) == 1)
					off = -off;
			end
			v.comp[c] = base.comp[c] + CRD_W'(off);
		end
		return v;
	endfunction

	task automatic push_vertex(input vertex_t v);
		vertices_to_send = {vertices_to_send, v};
		vertices_queued++;
	endtask

	task automatic drain();
		do @(posedge clk); while (results_seen < vertices_queued);
	endtask

	task automatic write_tolerance(input logic [tvd_pkg::TOL_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= tvd_pkg::REG_TOL;
		pwdata  <= {(tvd_pkg::PDATA_W-tvd_pkg::TOL_W)'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tol_model = int'(value);
		// read it back
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== tvd_pkg::PDATA_W'(value)) begin
			$error("match_tolerance: expected %0d, actual %0d", value, prdata);
			fault_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Meshes: mostly opened by a clear, then vertices drawn from a small set of bases, plus stray noise
	task automatic queue_meshes(input int count);
		vertex_t bases [$];
		vertex_t v;
		int      span;
		int      left;
		int      nbase;
		int      nitems;
		span = (tol_model > 4094) ? 4096 : tol_model + 2;
		left = count;
		while (left > 0) begin
			nbase = $urandom_range(1, 24);
			bases.delete();
			for (int k = 0; k < nbase; k++) begin
				if (k > 0 && $urandom_range(0, 3) == 0)
					bases = {bases, jitter(bases[k-1], span)};
				else
					bases = {bases, random_vertex(1'b0)};
			end
			nitems = $urandom_range(nbase, 3 * nbase);
			for (int j = 0; j < nitems && left > 0; j++) begin
				if ($urandom_range(0, 9) == 0) begin
					v = random_vertex(1'($urandom_range(0, 1)));
				end else begin
					v = bases[$urandom_range(0, nbase - 1)];
					if ($urandom_range(0, 1) == 1)
						v = jitter(v, span);
					v.clear = (j == 0) && ($urandom_range(0, 7) != 0);
				end
				push_vertex(v);
				left--;
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			vtx_valid <= 1'b0;
		end else if (!vtx_valid || !vtx_stall) begin
			if (vertices_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				next_item = vertices_to_send.pop_front();
				vtx_valid   <= 1'b1;
				clear_table <= next_item.clear;
				pos_x       <= next_item.comp[0];
				pos_y       <= next_item.comp[1];
				pos_z       <= next_item.comp[2];
				tex_u       <= next_item.comp[3];
				tex_v       <= next_item.comp[4];
				norm_x      <= next_item.comp[5];
				norm_y      <= next_item.comp[6];
				norm_z      <= next_item.comp[7];
			end else begin
				vtx_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_asks) begin
			// long hold-off: let the block back up and stall its input
			res_stall   <= 1'b1;
			hold_left   <= HOLD_CYCLES;
			hold_served <= hold_served + 1;
		end else begin
			res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && vtx_valid && !vtx_stall)
			indices_due = {indices_due, lookup_vertex({clear_table, norm_z, norm_y, norm_x,
				tex_v, tex_u, pos_z, pos_y, pos_x})};
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (indices_due.size() == 0) begin
				$error("result with no vertex pending: vertex_index %0d", vertex_index);
				fault_count++;
			end else begin
				next_due = indices_due.pop_front();
				if (vertex_index !== next_due.idx) begin
					$error("vertex_index: expected %0d, actual %0d", next_due.idx, vertex_index);
					fault_count++;
				end
				if (is_new !== next_due.fresh) begin
					$error("is_new: expected %0b, actual %0b", next_due.fresh, is_new);
					fault_count++;
				end
				if (table_full !== next_due.full) begin
					$error("table_full: expected %0b, actual %0b", next_due.full, table_full);
					fault_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (vtx_valid && !vtx_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		vertex_t v;
		vertex_t last_fill;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Boundaries at the reset tolerance, extremes, clear with a vertex
		push_vertex(flat_vertex(1'b1, '0));
		push_vertex(flat_vertex(1'b0, CRD_W'(40)));
		v = flat_vertex(1'b0, '0);
		v.comp[0] = CRD_W'(41);
		push_vertex(v);
		v = flat_vertex(1'b0, '0);
		v.comp[NCOMP-1] = CRD_W'(-41);
		push_vertex(v);
		push_vertex(flat_vertex(1'b0, CRD_W'(-40)));
		push_vertex(flat_vertex(1'b0, COORD_MAX));
		push_vertex(flat_vertex(1'b0, COORD_MIN));
		push_vertex(flat_vertex(1'b0, {(CRD_W/2){2'b01}}));
		push_vertex(flat_vertex(1'b0, {(CRD_W/2){2'b10}}));
		push_vertex(flat_vertex(1'b0, COORD_MAX - CRD_W'(40)));
		push_vertex(flat_vertex(1'b1, COORD_MAX));
		push_vertex(flat_vertex(1'b0, COORD_MAX));
		drain();

		write_tolerance(TOL_MAX);
		push_vertex(flat_vertex(1'b1, COORD_MIN));
		push_vertex(flat_vertex(1'b0, COORD_MAX));
		push_vertex(flat_vertex(1'b0, '0));
		push_vertex(flat_vertex(1'b0, CRD_W'(1)));
		drain();

		// Zero tolerance: every vertex appends, even exact repeats
		write_tolerance('0);
		push_vertex(flat_vertex(1'b1, CRD_W'(5)));
		push_vertex(flat_vertex(1'b0, CRD_W'(5)));
		push_vertex(flat_vertex(1'b0, CRD_W'(5)));
		drain();

		// Fill the whole table, then overflow it
		for (int k = 0; k < tvd_pkg::TABLE_DEPTH + 3; k++) begin
			v = random_vertex(k == 0);
			if (k == tvd_pkg::TABLE_DEPTH - 1)
				last_fill = v;
			push_vertex(v);
		end
		drain();
		write_tolerance(tvd_pkg::TOL_W'(1));
		last_fill.clear = 1'b0;
		push_vertex(last_fill);
		push_vertex(random_vertex(1'b0));
		push_vertex(random_vertex(1'b1));
		drain();

		for (int r = 0; r < ROUNDS; r++) begin
			case (r)
				0: write_tolerance(tvd_pkg::TOL_RESET);
				1: write_tolerance(tvd_pkg::TOL_W'(1));
				2: write_tolerance(tvd_pkg::TOL_W'(300));
				3: write_tolerance(tvd_pkg::TOL_W'($urandom_range(2, 5000)));
				4: write_tolerance(TOL_MAX);
				default: write_tolerance(tvd_pkg::TOL_W'($urandom));
			endcase
			send_idle_pct = (r == 1) ? 0 : 18;
			recv_idle_pct = send_idle_pct;
			if (r == 2)
				hold_asks++;
			queue_meshes(MESH_ITEMS / ROUNDS);
			drain();
		end

		repeat (tvd_pkg::TABLE_DEPTH + 16) @(posedge clk);
		if (indices_due.size() != 0) begin
			$error("%0d expected results never arrived", indices_due.size());
			fault_count++;
		end
		if (fault_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/core/tvd_pkg.sv
rtl/core/tvd_store.sv
rtl/core/tvd_match.sv
rtl/core/tolerant_vertex_dedup.sv
rtl/core/tvd_checker.sv
verif/tolerant_vertex_dedup_test.sv
